[rtl/smpq_pkg.sv]
// Shared types and constants for the sorted max priority queue.
`default_nettype none
package smpq_pkg;

    localparam int DEFAULT_CAPACITY = 16;
    localparam int WORD_W           = 32;
    localparam int STATUS_W         = 2;
    localparam int COUNT_OUT_W      = 5;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd2;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    // Per-cycle command broadcast to every cell.
    typedef struct packed {
        logic insert_en;
        logic remove_en;
    } cell_ctrl_t;

endpackage
`default_nettype wire

[rtl/sorted_max_priority_queue.sv]
// Top level of the sorted max priority queue: cell chain, count and result register.
// Result and done are registered and are on the ports in the cycle after acceptance.
// Throughput: one request per cycle, busy stays low; the receiver cannot stall.
// Reset (rst_n low, asynchronous) empties the queue and clears done; entry cells
// keep their contents, since only entries below the count are ever read.
`default_nettype none
module sorted_max_priority_queue
    import smpq_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
)
(
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             start,
    output logic                            busy,
    input  wire                             mode,
    input  wire logic signed [WORD_W-1:0]   new_value,
    output logic                            done,
    output logic [STATUS_W-1:0]             status,
    output logic signed [WORD_W-1:0]        removed_value,
    output logic [COUNT_OUT_W-1:0]          count_after
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    // Queue fill count.
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    // Result registers.
    logic                      done_reg;
    logic [STATUS_W-1:0]       status_reg;
    logic [STATUS_W-1:0]       status_next;
    logic signed [WORD_W-1:0]  removed_reg;
    logic signed [WORD_W-1:0]  removed_next;
    logic [COUNT_OUT_W-1:0]    count_out_reg;

    logic       accept;
    logic       full;
    logic       empty;
    cell_ctrl_t ctrl;

    // Chain wiring.
    logic signed [WORD_W-1:0] cell_value [CAPACITY];
    logic                     cell_ge    [CAPACITY];

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign full   = (count_reg == CAP_CNT);
    assign empty  = (count_reg == '0);

    // Full inserts and empty removes leave the chain untouched.
    assign ctrl.insert_en = accept && (mode == MODE_INSERT) && !full;
    assign ctrl.remove_en = accept && (mode == MODE_REMOVE) && !empty;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic                     occ;
            logic signed [WORD_W-1:0] lval;
            logic                     lge;
            logic signed [WORD_W-1:0] rval;

            assign occ = (CNT_W'(gi) < count_reg);

            if (gi == 0)
            begin : g_head
                // Head cell: the new value lands here if nothing ahead wins.
                assign lval = new_value;
                assign lge  = 1'b1;
            end
            else
            begin : g_body
                assign lval = cell_value[gi-1];
                assign lge  = cell_ge[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_tail
                assign rval = cell_value[gi];
            end
            else
            begin : g_mid
                assign rval = cell_value[gi+1];
            end

            smpq_cell u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .new_value   (new_value),
                .occupied    (occ),
                .left_value  (lval),
                .left_ge     (lge),
                .right_value (rval),
                .value       (cell_value[gi]),
                .ge          (cell_ge[gi])
            );
        end
    endgenerate

    always_comb
    begin
        count_next   = count_reg;
        status_next  = STATUS_OK;
        removed_next = '0;
        if (mode == MODE_INSERT)
        begin
            if (full)
            begin
                status_next = STATUS_OVERFLOW;
            end
            else
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
        else
        begin
            if (empty)
            begin
                status_next = STATUS_UNDERFLOW;
            end
            else
            begin
                count_next   = count_reg - CNT_W'(1);
                removed_next = cell_value[0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= accept;
            if (accept)
            begin
                count_reg <= count_next;
            end
        end
    end

    // Payload side of the result, no reset needed.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg    <= status_next;
            removed_reg   <= removed_next;
            count_out_reg <= COUNT_OUT_W'(count_next);
        end
    end

    assign done          = done_reg;
    assign status        = status_reg;
    assign removed_value = removed_reg;
    assign count_after   = count_out_reg;

endmodule
`default_nettype wire

[rtl/smpq_cell.sv]
// One storage cell of the sorted chain: holds an entry, shifts left or right.
`default_nettype none
module smpq_cell
    import smpq_pkg::*;
(
    input  wire                      clk,
    input  wire cell_ctrl_t          ctrl,
    input  wire logic signed [WORD_W-1:0] new_value,
    input  wire                      occupied,
    input  wire logic signed [WORD_W-1:0] left_value,
    input  wire                      left_ge,
    input  wire logic signed [WORD_W-1:0] right_value,
    output logic signed [WORD_W-1:0] value,
    output logic                     ge
);

    logic signed [WORD_W-1:0] value_reg;
    logic signed [WORD_W-1:0] value_next;

    // Entry stays put when it is >= the incoming value (equal values stay ahead).
    assign ge    = occupied && (value_reg >= new_value);
    assign value = value_reg;

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.insert_en)
        begin
            if (!ge)
            begin
                value_next = left_ge ? new_value : left_value;
            end
        end
        else if (ctrl.remove_en)
        begin
            value_next = right_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule
`default_nettype wire
